FILE: rtl/aesctr_pkg.sv
// Shared types, constants and AES byte functions for the counter-mode keystream block.
package aesctr_pkg;

    localparam int KEY_ENTRIES = 30;
    localparam int ROUNDS      = 14;
    localparam int KADDR_W     = 5;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CTR_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CTR_HI = 3'd5;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic       restart;
        logic [4:0] byte_count;
    } t_req;

    typedef struct packed {
        logic [63:0] stream_low;
        logic [63:0] stream_high;
        logic [4:0]  valid_bytes;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [63:0]          data;
    } t_cfg;

    function automatic t_byte sbox(input t_byte a);
        t_byte r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic t_byte xtime(input t_byte b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte rcon(input logic [2:0] i);
        return 8'h01 << i;
    endfunction

    // One AES round on a 128-bit state, byte i at bits 8i+7:8i.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        t_byte       t [16];
        t_byte       m [16];
        t_byte       a0, a1, a2, a3, x;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) t[i] = sbox(s[8*i +: 8]);
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) m[i + 4*c] = t[i + 4*((c + i) % 4)];
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = m[4*c]; a1 = m[4*c+1]; a2 = m[4*c+2]; a3 = m[4*c+3];
                x = a0 ^ a1 ^ a2 ^ a3;
                m[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
                m[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
                m[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
                m[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) o[8*i +: 8] = m[i];
        return o;
    endfunction

endpackage

FILE: rtl/aesctr_if.sv
// Valid/ready channel interface with a generic payload.
interface aesctr_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/aesctr_ram.sv
// Generic single-port synchronous RAM with registered read.
module aesctr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/aesctr_keyexp.sv
// AES-256 key expansion: produces one 64-bit round key entry per cycle.
module aesctr_keyexp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_key0,
    input  logic [63:0] i_key1,
    input  logic [63:0] i_key2,
    input  logic [63:0] i_key3,
    output logic        o_we,
    output logic [aesctr_pkg::KADDR_W-1:0] o_addr,
    output logic [63:0] o_wdata,
    output logic        o_done
);
    localparam int KW = aesctr_pkg::KADDR_W;

    logic          r_busy, n_busy;
    logic [KW-1:0] r_idx, n_idx;
    logic [31:0]   r_w [8];
    logic [31:0]   n_w [8];
    logic [31:0]   t0, t1, w8, w9;
    logic [2:0]    rci;

    // entry idx holds words 2idx, 2idx+1; window r_w holds the last 8 words
    always_comb begin
        rci = r_idx[4:2] - 3'd1;
        if (r_idx[1:0] == 2'd0) begin
            t0 = aesctr_pkg::sub_word({r_w[7][7:0], r_w[7][31:8]})
                 ^ {24'd0, aesctr_pkg::rcon(rci)};
        end else if (r_idx[1:0] == 2'd2) begin
            t0 = aesctr_pkg::sub_word(r_w[7]);
        end else begin
            t0 = r_w[7];
        end
        w8 = r_w[0] ^ t0;
        t1 = w8;
        w9 = r_w[1] ^ t1;
        n_busy = r_busy;
        n_idx  = r_idx;
        for (int i = 0; i < 8; i++) n_w[i] = r_w[i];
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_w[0] = i_key0[31:0]; n_w[1] = i_key0[63:32];
            n_w[2] = i_key1[31:0]; n_w[3] = i_key1[63:32];
            n_w[4] = i_key2[31:0]; n_w[5] = i_key2[63:32];
            n_w[6] = i_key3[31:0]; n_w[7] = i_key3[63:32];
        end else if (r_busy) begin
            n_idx = r_idx + KW'(1);
            if (r_idx >= KW'(4)) begin
                for (int i = 0; i < 6; i++) n_w[i] = r_w[i+2];
                n_w[6] = w8;
                n_w[7] = w9;
            end
            if (r_idx == KW'(aesctr_pkg::KEY_ENTRIES - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        for (int i = 0; i < 8; i++) r_w[i] <= n_w[i];
    end

    assign o_we    = r_busy;
    assign o_addr  = r_idx;
    assign o_wdata = (r_idx < KW'(4)) ? (r_idx == KW'(0) ? {r_w[1], r_w[0]} :
                     r_idx == KW'(1) ? {r_w[3], r_w[2]} :
                     r_idx == KW'(2) ? {r_w[5], r_w[4]} : {r_w[7], r_w[6]})
                     : {w9, w8};
    assign o_done  = r_busy && (r_idx == KW'(aesctr_pkg::KEY_ENTRIES - 1));
endmodule

FILE: rtl/aes256_ctr_keystream_generator_top.sv
// Top level: AES-256 counter-mode keystream generator around a round-key RAM.
//
//  channel   dir  payload                                   handshake
//  i_req     in   restart, byte_count                       valid/ready
//  o_rsp     out  stream_low, stream_high, valid_bytes      valid/ready
//  i_cfg     in   index (3b), data (64b)                    valid/ready
//
// A request runs key expansion first on restart, then 15 rounds, each of two
// RAM reads for the 64-bit key halves through the single port and one apply,
// then an output state. A new request is taken only once the last one is through.
// A zero byte count skips the rounds and leaves the counter alone.
// Reset clears state, counter, key and config; key RAM is undefined until a restart.
// The result register holds while o_rsp is stalled; a new request is taken
// meanwhile and stalls in the output cycle only until the held result leaves.
module aes256_ctr_keystream_generator_top (
    input  logic i_clk,
    input  logic i_rst_n,
    aesctr_if.sink   i_req,
    aesctr_if.source o_rsp,
    aesctr_if.sink   i_cfg
);
    localparam int KW = aesctr_pkg::KADDR_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEXP = 3'd1;
    localparam logic [2:0] ST_RDLO = 3'd2;
    localparam logic [2:0] ST_RDHI = 3'd3;
    localparam logic [2:0] ST_APPLY = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]   r_st, n_st;
    logic [63:0]  r_key [4];
    logic [63:0]  r_sc_lo, r_sc_hi, r_ctr_lo, r_ctr_hi;
    logic [4:0]   r_cnt;
    logic [3:0]   r_rnd;
    logic [127:0] r_s;
    logic [63:0]  r_klo;
    logic         r_ovld;
    aesctr_pkg::t_rsp r_rsp;

    logic          ke_we, ke_done;
    logic [KW-1:0] ke_addr, rd_addr, ram_addr;
    logic [63:0]   ke_wdata, ram_rdata;
    logic [127:0]  rk, s_next, ks;
    logic [4:0]    cnt_sat;
    logic          req_acc;
    logic          out_load;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_st == ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign cnt_sat     = (i_req.data.byte_count > 5'd16) ? 5'd16 : i_req.data.byte_count;
    assign out_load    = (r_st == ST_OUT) && (!r_ovld || o_rsp.ready);

    aesctr_keyexp u_kexp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(req_acc && i_req.data.restart),
        .i_key0(r_key[0]), .i_key1(r_key[1]), .i_key2(r_key[2]), .i_key3(r_key[3]),
        .o_we(ke_we), .o_addr(ke_addr), .o_wdata(ke_wdata), .o_done(ke_done)
    );

    assign rd_addr  = {r_rnd, (r_st == ST_RDHI)};
    assign ram_addr = ke_we ? ke_addr : rd_addr;

    aesctr_ram #(.WIDTH(64), .DEPTH(32)) u_keys (
        .i_clk(i_clk), .i_we(ke_we), .i_addr(ram_addr),
        .i_wdata(ke_wdata), .o_rdata(ram_rdata)
    );

    assign rk     = {ram_rdata, r_klo};
    assign s_next = (r_rnd == 4'd0) ? (r_s ^ rk)
                    : (aesctr_pkg::aes_round(r_s, r_rnd == 4'(aesctr_pkg::ROUNDS)) ^ rk);

    always_comb begin
        for (int i = 0; i < 16; i++)
            ks[8*i +: 8] = (5'(i) < r_cnt) ? r_s[8*i +: 8] : 8'h00;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (req_acc) begin
                n_st = i_req.data.restart ? ST_KEXP : (cnt_sat == 5'd0 ? ST_OUT : ST_RDLO);
            end
            ST_KEXP:  if (ke_done) begin
                n_st = (r_cnt == 5'd0) ? ST_OUT : ST_RDLO;
            end
            ST_RDLO:  n_st = ST_RDHI;
            ST_RDHI:  n_st = ST_APPLY;
            ST_APPLY: n_st = (r_rnd == 4'(aesctr_pkg::ROUNDS)) ? ST_OUT : ST_RDLO;
            ST_OUT:   if (out_load) begin
                n_st = ST_IDLE;
            end
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
            r_sc_lo  <= '0;
            r_sc_hi  <= '0;
            r_ctr_lo <= '0;
            r_ctr_hi <= '0;
            r_ovld   <= 1'b0;
            r_rnd    <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg.valid) begin
                case (i_cfg.data.index)
                    aesctr_pkg::REG_KEY0:   r_key[0] <= i_cfg.data.data;
                    aesctr_pkg::REG_KEY1:   r_key[1] <= i_cfg.data.data;
                    aesctr_pkg::REG_KEY2:   r_key[2] <= i_cfg.data.data;
                    aesctr_pkg::REG_KEY3:   r_key[3] <= i_cfg.data.data;
                    aesctr_pkg::REG_CTR_LO: r_sc_lo  <= i_cfg.data.data;
                    aesctr_pkg::REG_CTR_HI: r_sc_hi  <= i_cfg.data.data;
                    default: ;
                endcase
            end
            if (req_acc) begin
                r_rnd <= '0;
                if (i_req.data.restart) begin
                    r_ctr_lo <= r_sc_lo;
                    r_ctr_hi <= r_sc_hi;
                end
            end
            if (r_st == ST_APPLY) begin
                r_rnd <= r_rnd + 4'd1;
            end
            // advance the low counter lane after the last round
            if (r_st == ST_APPLY && r_rnd == 4'(aesctr_pkg::ROUNDS)) begin
                r_ctr_lo[31:0] <= r_ctr_lo[31:0] + 32'd1;
            end
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_cnt <= cnt_sat;
        end
        if (r_st == ST_RDLO && r_rnd == 4'd0) begin
            r_s <= {r_ctr_hi, r_ctr_lo};
        end
        if (r_st == ST_RDHI) begin
            r_klo <= ram_rdata;
        end
        if (r_st == ST_APPLY) begin
            r_s <= s_next;
        end
        if (out_load) begin
            r_rsp.stream_low  <= ks[63:0];
            r_rsp.stream_high <= ks[127:64];
            r_rsp.valid_bytes <= r_cnt;
        end
    end

    assign o_rsp.valid = r_ovld;
    assign o_rsp.data  = r_rsp;

    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_st != ST_IDLE)) else $error("request not taken up");
    a_no_rd_in_kexp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ke_we |-> (r_st == ST_KEXP)) else $error("key write outside expansion");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !o_rsp.ready) |=> r_ovld) else $error("result dropped");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT) |-> (r_cnt <= 5'd16)) else $error("count out of range");
endmodule
